[src/ssnf_pkg.sv]
// ----------------------------------------------------------------------------
// ssnf_pkg: shared types and constants of the seven-segment number formatter
// Symbol codes, digit count and the structs that travel between the stages.
// ----------------------------------------------------------------------------
package ssnf_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int SYM_W = 4;
	localparam int POS_W = 3;

	localparam logic [SYM_W-1:0] SYM_ZERO  = 4'd0;
	localparam logic [SYM_W-1:0] SYM_MINUS = 4'd10;
	localparam logic [SYM_W-1:0] SYM_BLANK = 4'd11;
	localparam logic [SYM_W-1:0] SYM_E     = 4'd12;
	localparam logic [SYM_W-1:0] SYM_R     = 4'd13;

	// Largest magnitudes that fit the display with and without a minus.
	localparam logic [15:0] MAX_NEG = 16'd999;
	localparam logic [15:0] MAX_POS = 16'd9999;
	localparam logic [2:0]  MAX_POINT = 3'd4;

	// Position of the point in the error display.
	localparam logic [2:0] ERR_POINT_POS = 3'd3;

	typedef struct packed {
		logic       err;
		logic       neg;
		logic [2:0] pp;
		logic       blank;
	} ssnf_mode_t;

	typedef struct packed {
		ssnf_mode_t mode;
		logic [3:0] d3;   // thousands
		logic [3:0] d2;   // hundreds
		logic [3:0] d1;   // tens
		logic [3:0] d0;   // ones
	} ssnf_digits_t;

	typedef struct packed {
		logic [DIGIT_COUNT-1:0][SYM_W-1:0] sym;  // index 0 is position 1
		logic [DIGIT_COUNT-1:0]            pt;
	} ssnf_disp_t;

endpackage

[src/ssnf_split.sv]
// ----------------------------------------------------------------------------
// ssnf_split: range check and decimal digit extraction
// Four pipeline stages split the magnitude into hundreds and units pairs, then
// each pair into two digits, using reciprocal multiplications by constants.
// ----------------------------------------------------------------------------
module ssnf_split (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           magnitude,
	input  logic                  negative,
	input  logic [2:0]            point_position,
	input  logic                  blank_leading,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ssnf_pkg::ssnf_digits_t out_digits
);

	logic rdy1, rdy2, rdy3, rdy4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	ssnf_pkg::ssnf_mode_t mode_s1, mode_s2, mode_s3, mode_s4;
	logic [13:0] mag_s1;
	logic [6:0]  hi_s1, hi_s2, lo_s2, lo_s3, lo_s4;
	logic [3:0]  th_s2, th_s3, th_s4, hu_s3, hu_s4, tl_s3, tl_s4;

	logic [29:0] hi_prod;
	logic        err_in;
	logic [13:0] hi_x100;
	logic [13:0] lo_full;
	logic [14:0] th_prod;
	logic [6:0]  th_x10;
	logic [6:0]  hu_full;
	logic [14:0] tl_prod;
	logic [6:0]  tl_x10;
	logic [6:0]  lu_full;

	assign rdy4     = !valid_s4 || out_ready;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	// Stage 1: x / 100 as (x * 5243) >> 19, exact for every x up to 9999.
	assign hi_prod = 30'(magnitude) * 30'd5243;
	assign err_in  = (negative && magnitude > ssnf_pkg::MAX_NEG) ||
		(!negative && magnitude > ssnf_pkg::MAX_POS) ||
		(point_position > ssnf_pkg::MAX_POINT) ||
		(point_position == 3'd1 && negative);

	// Stage 2: remainder of the hundreds split, tens of the upper pair.
	assign hi_x100 = 14'(hi_s1) * 14'd100;
	assign lo_full = mag_s1 - hi_x100;
	assign th_prod = 15'(hi_s1) * 15'd205;

	// Stage 3: units of the upper pair, tens of the lower pair.
	assign th_x10  = 7'(th_s2) * 7'd10;
	assign hu_full = hi_s2 - th_x10;
	assign tl_prod = 15'(lo_s2) * 15'd205;

	// Stage 4 output: units of the lower pair.
	assign tl_x10  = 7'(tl_s4) * 7'd10;
	assign lu_full = lo_s4 - tl_x10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			mode_s1 <= '{err: err_in, neg: negative, pp: point_position,
				blank: blank_leading};
			mag_s1  <= magnitude[13:0];
			hi_s1   <= hi_prod[25:19];
		end
		if (rdy2 && valid_s1) begin
			mode_s2 <= mode_s1;
			hi_s2   <= hi_s1;
			lo_s2   <= lo_full[6:0];
			th_s2   <= th_prod[14:11];
		end
		if (rdy3 && valid_s2) begin
			mode_s3 <= mode_s2;
			lo_s3   <= lo_s2;
			th_s3   <= th_s2;
			hu_s3   <= hu_full[3:0];
			tl_s3   <= tl_prod[14:11];
		end
		if (rdy4 && valid_s3) begin
			mode_s4 <= mode_s3;
			lo_s4   <= lo_s3;
			th_s4   <= th_s3;
			hu_s4   <= hu_s3;
			tl_s4   <= tl_s3;
		end
	end

	assign out_valid       = valid_s4;
	assign out_digits.mode = mode_s4;
	assign out_digits.d3   = th_s4;
	assign out_digits.d2   = hu_s4;
	assign out_digits.d1   = tl_s4;
	assign out_digits.d0   = lu_full[3:0];

endmodule

[src/ssnf_format.sv]
// ----------------------------------------------------------------------------
// ssnf_format: symbol placement stage
// Fills leading positions with zeros or blanks, places the minus and the
// point, and substitutes the error display for words with the error flag set.
// ----------------------------------------------------------------------------
module ssnf_format (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ssnf_pkg::ssnf_digits_t in_digits,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ssnf_pkg::ssnf_disp_t   out_disp
);

	logic                 valid_s5;
	ssnf_pkg::ssnf_disp_t disp_s5;
	ssnf_pkg::ssnf_disp_t disp_d;
	logic [1:0]           nlead;
	logic [ssnf_pkg::DIGIT_COUNT-1:0][ssnf_pkg::SYM_W-1:0] digit;
	logic [ssnf_pkg::SYM_W-1:0] fill;

	assign in_ready = !valid_s5 || out_ready;

	always_comb begin
		digit[0] = in_digits.d3;
		digit[1] = in_digits.d2;
		digit[2] = in_digits.d1;
		digit[3] = in_digits.d0;

		// Positions left of the most significant digit; zero shows one digit.
		if (in_digits.d3 != 4'd0)      nlead = 2'd0;
		else if (in_digits.d2 != 4'd0) nlead = 2'd1;
		else if (in_digits.d1 != 4'd0) nlead = 2'd2;
		else                           nlead = 2'd3;

		fill = in_digits.mode.blank ? ssnf_pkg::SYM_BLANK : ssnf_pkg::SYM_ZERO;

		for (int i = 0; i < ssnf_pkg::DIGIT_COUNT; i++) begin
			disp_d.sym[i] = (2'(i) < nlead) ? fill : digit[i];
			disp_d.pt[i]  = (in_digits.mode.pp == 3'(i + 1));
		end

		if (in_digits.mode.neg) begin
			if (!in_digits.mode.blank)
				disp_d.sym[0] = ssnf_pkg::SYM_MINUS;
			else if (nlead != 2'd0)
				disp_d.sym[2'(nlead - 2'd1)] = ssnf_pkg::SYM_MINUS;
		end

		if (in_digits.mode.err) begin
			disp_d.sym[0] = ssnf_pkg::SYM_E;
			disp_d.sym[1] = ssnf_pkg::SYM_R;
			disp_d.sym[2] = ssnf_pkg::SYM_R;
			disp_d.sym[3] = ssnf_pkg::SYM_ZERO;
			for (int i = 0; i < ssnf_pkg::DIGIT_COUNT; i++)
				disp_d.pt[i] = (ssnf_pkg::ERR_POINT_POS == 3'(i + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (in_ready) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) disp_s5 <= disp_d;
	end

	assign out_valid = valid_s5;
	assign out_disp  = disp_s5;

endmodule

[src/ssnf_serial.sv]
// ----------------------------------------------------------------------------
// ssnf_serial: output serializer
// Holds one formatted display and sends its four positions, leftmost first,
// taking the next display in the cycle the last position leaves.
// ----------------------------------------------------------------------------
module ssnf_serial (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ssnf_pkg::ssnf_disp_t in_disp,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           position,
	output logic [3:0]           symbol,
	output logic                 point_on,
	output logic                 last_digit
);

	logic                 valid_q;
	logic [1:0]           idx_q;
	ssnf_pkg::ssnf_disp_t disp_q;
	logic                 at_last;
	logic                 out_fire;

	assign at_last  = (idx_q == 2'(ssnf_pkg::DIGIT_COUNT - 1));
	assign out_fire = valid_q && out_ready;
	assign in_ready = !valid_q || (out_ready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (in_ready) begin
			valid_q <= in_valid;
			idx_q   <= 2'd0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) disp_q <= in_disp;
	end

	assign out_valid  = valid_q;
	assign position   = 3'(idx_q) + 3'd1;
	assign symbol     = disp_q.sym[idx_q];
	assign point_on   = disp_q.pt[idx_q];
	assign last_digit = at_last;

endmodule

[src/seven_segment_number_formatter.sv]
// ----------------------------------------------------------------------------
// seven_segment_number_formatter: four-position decimal display formatter
// Turns a magnitude, a minus flag, a point position and a leading-zero mode
// into four symbol words, one per display position, leftmost first.
// ----------------------------------------------------------------------------
// Use: present a word on the s_ group; it is taken when s_tvalid and s_tready
// are both high. Each word yields four words on the m_ group carrying the
// position (1..4), a symbol code and the point flag; m_tlast marks the
// fourth. Out-of-range words, and a minus with the point at position 1, give the error display E r r 0.
// Path: each input word passes four digit-split stages, one formatting stage
// and the serializer register before its first result word appears.
// Flow: the serializer sends one position per cycle while m_tready is high
// and takes a new word as the last position of the previous one leaves; the
// pipeline ahead keeps taking new words while it drains, up to one word per stage.
// Reset: arst_n clears every valid bit at once; s_tready is already high
// during reset, so a word can be taken at the first edge after release. A
// stall on m_tready holds the current result word and, as the stages fill,
// eventually drops s_tready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] magnitude, [16] negative, [19:17] point_position,
	// [20] blank_leading, [23:21] zero
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] position, [6:3] symbol, [7] point_on
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	logic                   split_valid, split_ready;
	ssnf_pkg::ssnf_digits_t split_digits;
	logic                   fmt_valid, fmt_ready;
	ssnf_pkg::ssnf_disp_t   fmt_disp;
	logic [2:0]             position;
	logic [3:0]             symbol;
	logic                   point_on;

	ssnf_split u_split (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.magnitude     (s_tdata[15:0]),
		.negative      (s_tdata[16]),
		.point_position(s_tdata[19:17]),
		.blank_leading (s_tdata[20]),
		.out_valid     (split_valid),
		.out_ready     (split_ready),
		.out_digits    (split_digits)
	);

	ssnf_format u_format (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (split_valid),
		.in_ready (split_ready),
		.in_digits(split_digits),
		.out_valid(fmt_valid),
		.out_ready(fmt_ready),
		.out_disp (fmt_disp)
	);

	ssnf_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fmt_valid),
		.in_ready  (fmt_ready),
		.in_disp   (fmt_disp),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.position  (position),
		.symbol    (symbol),
		.point_on  (point_on),
		.last_digit(m_tlast)
	);

	assign m_tdata = {point_on, symbol, position};

`ifndef SYNTHESIS
	// After a non-final word leaves, the next position of the same display follows.
	a_next_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1))
		else $error("serializer skipped or repeated a position");

	// A new display always starts at the leftmost position.
	a_first_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || m_tdata[2:0] == 3'd1))
		else $error("display did not start at position 1");

	// The last marker sits exactly on the fourth position.
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[2:0] == 3'd4)))
		else $error("last marker not on position 4");

	// Only defined symbol codes reach the output.
	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:3] <= ssnf_pkg::SYM_R))
		else $error("undefined symbol code");
`endif

endmodule

[tb/seven_segment_number_formatter_test.sv]
// ----------------------------------------------------------------------------
// seven_segment_number_formatter_test: self-checking bench for the formatter
// Feeds number words through the stream input, predicts the four display
// words of each one and compares every output word field by field, in order.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 400;
	localparam int SETTLE_CYCLES = 12;

	typedef logic [ssnf_pkg::SYM_W-1:0] sym_t;
	typedef logic [ssnf_pkg::POS_W-1:0] pos_t;

	typedef struct packed {
		logic [15:0] magnitude;
		logic        negative;
		logic [2:0]  point_position;
		logic        blank_leading;
	} number_t;

	typedef struct {
		number_t     num;
		int unsigned idle_before;
		bit          drain_first;
	} pending_t;

	typedef struct packed {
		pos_t position;
		sym_t symbol;
		logic point_on;
		logic last_digit;
	} digit_word_t;

	typedef digit_word_t [ssnf_pkg::DIGIT_COUNT-1:0] display_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	pending_t    pending_words[$];
	digit_word_t expected_digits[$];
	int          error_count = 0;
	int          cycle_count = 0;

	seven_segment_number_formatter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Expected display for one number word, index 0 is the leftmost position.
	function automatic display_t format_display(input number_t n);
		display_t                         disp;
		sym_t                             sym[ssnf_pkg::DIGIT_COUNT];
		logic [ssnf_pkg::DIGIT_COUNT-1:0] pt;
		int                               ndig;
		int                               rem;
		bit                               bad;
		bad = (n.negative && n.magnitude > ssnf_pkg::MAX_NEG) ||
			(!n.negative && n.magnitude > ssnf_pkg::MAX_POS) ||
			n.point_position > ssnf_pkg::MAX_POINT ||
			(n.point_position == 3'd1 && n.negative);
		if (bad) begin
			sym[0] = ssnf_pkg::SYM_E;
			sym[1] = ssnf_pkg::SYM_R;
			sym[2] = ssnf_pkg::SYM_R;
			sym[3] = ssnf_pkg::SYM_ZERO;
			for (int k = 0; k < ssnf_pkg::DIGIT_COUNT; k++)
				pt[k] = (k + 1 == int'(ssnf_pkg::ERR_POINT_POS));
		end else begin
			rem = int'(n.magnitude);
			ndig = (rem < 10) ? 1 : (rem < 100) ? 2 : (rem < 1000) ? 3 : 4;
			for (int k = ssnf_pkg::DIGIT_COUNT - 1; k >= 0; k--) begin
				sym[k] = sym_t'(rem % 10);
				rem = rem / 10;
			end
			for (int k = 0; k < ssnf_pkg::DIGIT_COUNT - ndig; k++)
				sym[k] = n.blank_leading ? ssnf_pkg::SYM_BLANK : ssnf_pkg::SYM_ZERO;
			// With blanking the minus hugs the most significant shown digit.
			if (n.negative) begin
				if (!n.blank_leading)
					sym[0] = ssnf_pkg::SYM_MINUS;
				else if (ndig < ssnf_pkg::DIGIT_COUNT)
					sym[ssnf_pkg::DIGIT_COUNT - 1 - ndig] = ssnf_pkg::SYM_MINUS;
			end
			for (int k = 0; k < ssnf_pkg::DIGIT_COUNT; k++)
				pt[k] = (k + 1 == int'(n.point_position));
		end
		for (int k = 0; k < ssnf_pkg::DIGIT_COUNT; k++) begin
			disp[k].position = pos_t'(k + 1);
			disp[k].symbol = sym[k];
			disp[k].point_on = pt[k];
			disp[k].last_digit = (k == ssnf_pkg::DIGIT_COUNT - 1);
		end
		return disp;
	endfunction

	function automatic int unsigned draw_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic number_t random_number();
		number_t n;
		int unsigned r;
		r = $urandom_range(0, 99);
		n.negative = 1'($urandom_range(0, 1));
		n.blank_leading = 1'($urandom_range(0, 1));
		n.point_position = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, 4));
		if (r < 25)
			n.magnitude = 16'($urandom_range(0, 65535));
		else if (r < 40)
			n.magnitude = 16'($urandom_range(0, 9));
		else if (r < 55)
			n.magnitude = 16'($urandom_range(10, 99));
		else if (r < 75)
			n.magnitude = 16'($urandom_range(100, 999));
		else
			n.magnitude = 16'($urandom_range(1000, 9999));
		return n;
	endfunction

	task automatic queue_number(input logic [15:0] mag, input logic neg,
		input logic [2:0] pp, input logic blank);
		pending_t p;
		p.num = '{magnitude: mag, negative: neg, point_position: pp,
			blank_leading: blank};
		p.idle_before = 0;
		p.drain_first = 1'b0;
		pending_words.push_back(p);
	endtask

	// Sender: each word at the head waits out its idle time, and a drain
	// word also waits until every outstanding display word has come back.
	always @(posedge clk) begin : driver
		static number_t     held;
		static int unsigned wait_left = 0;
		static bit          loaded = 1'b0;
		display_t           disp;
		logic               next_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			next_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				disp = format_display(held);
				for (int k = 0; k < ssnf_pkg::DIGIT_COUNT; k++)
					expected_digits.push_back(disp[k]);
				void'(pending_words.pop_front());
				next_valid = 1'b0;
				loaded = 1'b0;
			end
			if (!next_valid && pending_words.size() > 0) begin
				if (!loaded) begin
					wait_left = pending_words[0].idle_before;
					loaded = 1'b1;
				end
				if (wait_left > 0) begin
					wait_left--;
				end else if (!pending_words[0].drain_first ||
					expected_digits.size() == 0) begin
					held = pending_words[0].num;
					s_tdata <= {3'b000, held.blank_leading, held.point_position,
						held.negative, held.magnitude};
					next_valid = 1'b1;
				end
			end
			s_tvalid <= next_valid;
		end
	end

	// Receiver: checks each accepted word against the oldest prediction.
	always @(posedge clk) begin : monitor
		static int unsigned stall_left = 0;
		static bit          calm = 1'b0;
		digit_word_t        got;
		digit_word_t        want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.position = m_tdata[2:0];
				got.symbol = m_tdata[6:3];
				got.point_on = m_tdata[7];
				got.last_digit = m_tlast;
				if (expected_digits.size() == 0) begin
					$display("%0t: unexpected word, position %0d symbol %0d point %0b last %0b",
						$time, got.position, got.symbol, got.point_on, got.last_digit);
					error_count++;
				end else begin
					want = expected_digits.pop_front();
					if (got.position !== want.position) begin
						$display("%0t: position expected %0d actual %0d",
							$time, want.position, got.position);
						error_count++;
					end
					if (got.symbol !== want.symbol) begin
						$display("%0t: symbol at position %0d expected %0d actual %0d",
							$time, want.position, want.symbol, got.symbol);
						error_count++;
					end
					if (got.point_on !== want.point_on) begin
						$display("%0t: point at position %0d expected %0b actual %0b",
							$time, want.position, want.point_on, got.point_on);
						error_count++;
					end
					if (got.last_digit !== want.last_digit) begin
						$display("%0t: tlast at position %0d expected %0b actual %0b",
							$time, want.position, want.last_digit, got.last_digit);
						error_count++;
					end
				end
			end
			if ($urandom_range(0, 199) == 0)
				calm = !calm;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = draw_gap(calm);
				m_tready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		pending_t p;
		bit       calm;

		// Extremes, blanking with and without minus, points on blanks and minus.
		queue_number(16'd0,     1'b0, 3'd0, 1'b0);
		queue_number(16'd0,     1'b0, 3'd4, 1'b1);
		queue_number(16'd0,     1'b1, 3'd0, 1'b1);
		queue_number(16'd0,     1'b1, 3'd2, 1'b0);
		queue_number(16'd9999,  1'b0, 3'd1, 1'b0);
		queue_number(16'd9999,  1'b0, 3'd4, 1'b1);
		queue_number(16'd10000, 1'b0, 3'd0, 1'b0);
		queue_number(16'd65535, 1'b1, 3'd7, 1'b1);
		queue_number(16'd65535, 1'b0, 3'd0, 1'b0);
		queue_number(16'd999,   1'b1, 3'd4, 1'b1);
		queue_number(16'd999,   1'b1, 3'd2, 1'b0);
		queue_number(16'd1000,  1'b1, 3'd0, 1'b1);
		queue_number(16'd12,    1'b0, 3'd5, 1'b0);
		queue_number(16'd34,    1'b0, 3'd6, 1'b1);
		queue_number(16'd56,    1'b1, 3'd1, 1'b1);
		queue_number(16'd7,     1'b0, 3'd1, 1'b1);
		queue_number(16'd5,     1'b1, 3'd3, 1'b1);
		queue_number(16'd42,    1'b1, 3'd2, 1'b1);
		queue_number(16'd123,   1'b1, 3'd3, 1'b0);
		queue_number(16'd123,   1'b1, 3'd1, 1'b1);
		queue_number(16'd100,   1'b0, 3'd2, 1'b1);
		queue_number(16'd1234,  1'b0, 3'd3, 1'b1);
		queue_number(16'd8,     1'b0, 3'd0, 1'b0);
		pending_words[pending_words.size() - 1].drain_first = 1'b1;

		calm = 1'b0;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 40 == 0)
				calm = ($urandom_range(0, 2) == 0);
			p.num = random_number();
			p.idle_before = draw_gap(calm);
			p.drain_first = (i % 100 == 50);
			pending_words.push_back(p);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || expected_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
